[rtl/core/pmsd_pkg.sv]
// Shared types and constants of the partition maximum-sum block.
`default_nettype none
package pmsd_pkg;

	localparam int VAL_W    = 16;
	localparam int BEST_W   = 26;
	localparam int CFG_W    = 5;
	localparam int KMAX_DEF = 16;
	localparam int K_RESET  = 3;

	localparam logic [BEST_W-1:0] BEST_MAX = {BEST_W{1'b1}};

	typedef struct packed {
		logic [VAL_W-1:0] elem_value;
		logic             is_last;
	} elem_req_t;

	typedef struct packed {
		logic [BEST_W-1:0] prefix_best;
		logic              is_final;
	} result_req_t;

	// Running candidate that walks down the cell chain.
	typedef struct packed {
		logic [VAL_W-1:0]  peak;
		logic [BEST_W-1:0] best;
	} tok_t;

	typedef struct packed {
		logic shift;
		logic commit;
		logic clear;
	} cell_ctl_t;

endpackage
`default_nettype wire

[rtl/core/pmsd_if.sv]
// Valid/ready channel interfaces for elements and results.
`default_nettype none
interface pmsd_elem_if import pmsd_pkg::*; ();
	logic      valid;
	logic      ready;
	elem_req_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface pmsd_result_if import pmsd_pkg::*; ();
	logic        valid;
	logic        ready;
	result_req_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/core/partition_max_sum_dp.sv]
// Top level of the partition maximum-sum block: a chain of KMAX cells and its control.
//
// Elements arrive on elem_ch, one request per array element, with is_last on the
// final one. Each element yields exactly one request on result_ch carrying the
// best partition total of the array prefix seen so far; is_final copies is_last.
// The user writes the piece length limit through cfg_we/cfg_wdata only while the
// block is idle; the block does not enforce this. 0 acts as 1, above KMAX as KMAX.
// An accepted element is shifted into the chain at once. A candidate then walks
// the KMAX cells, one cell per cycle; once the walk ends and the output register
// is free the result is registered there, and the next element can be taken in
// the cycle after that, so a new element is not taken while one is still walking.
// The result sits in an output register, so a stalled receiver does not stop
// the next element from being accepted; a second result waits in the chain
// until the output register frees up.
// Reset clears the stored elements and totals and sets the piece limit to 3.
// The history is cleared again after every element marked last.
`default_nettype none
module partition_max_sum_dp import pmsd_pkg::*; #(
	parameter int KMAX = KMAX_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [CFG_W-1:0] cfg_wdata,
	pmsd_elem_if.sink             elem_ch,
	pmsd_result_if.source         result_ch
);

	localparam int LW = $clog2(KMAX + 1);

	logic [CFG_W-1:0]  k_q;
	logic              busy_q;
	logic [LW-1:0]     cnt_q;
	logic [LW-1:0]     seen_q;
	logic              last_q;
	logic              out_valid_q;
	result_req_t       out_data_q;

	logic              accept;
	logic              done;
	logic              out_free;
	logic              commit;
	logic [BEST_W-1:0] result;
	int                k_int;
	cell_ctl_t         ctl;

	logic [VAL_W-1:0]  values [KMAX];
	logic [BEST_W-1:0] bests  [KMAX];
	tok_t              toks   [KMAX];
	logic [KMAX-1:0]   active;

	assign elem_ch.ready   = !busy_q;
	assign accept          = elem_ch.valid && !busy_q;
	assign done            = busy_q && (cnt_q == LW'(KMAX));
	assign out_free        = !out_valid_q || result_ch.ready;
	assign commit          = done && out_free;
	assign result          = toks[KMAX-1].best;
	assign result_ch.valid = out_valid_q;
	assign result_ch.data  = out_data_q;

	always_comb begin
		k_int      = (k_q == '0) ? 1 : int'(k_q);
		ctl.shift  = accept;
		ctl.commit = commit;
		ctl.clear  = commit && last_q;
		for (int j = 0; j < KMAX; j++) begin
			// Piece length j+1 is allowed by the limit and by the elements seen.
			active[j] = (j < k_int) && (j <= int'(seen_q));
		end
	end

	for (genvar j = 0; j < KMAX; j++) begin : g_cell
		logic [VAL_W-1:0]  value_in;
		logic [BEST_W-1:0] best_in;
		tok_t              tok_in;

		if (j == 0) begin : g_head
			assign value_in = elem_ch.data.elem_value;
			assign best_in  = result;
			assign tok_in   = '0;
		end else begin : g_body
			assign value_in = values[j-1];
			assign best_in  = bests[j-1];
			assign tok_in   = toks[j-1];
		end

		pmsd_cell #(
			.KMAX (KMAX),
			.IDX  (j)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.active   (active[j]),
			.value_in (value_in),
			.best_in  (best_in),
			.tok_in   (tok_in),
			.value_q  (values[j]),
			.best_q   (bests[j]),
			.tok_s1   (toks[j])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= CFG_W'(K_RESET);
		end else if (cfg_we) begin
			k_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			seen_q <= '0;
		end else if (accept) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (commit) begin
			busy_q <= 1'b0;
			if (last_q) begin
				seen_q <= '0;
			end else if (seen_q < LW'(KMAX)) begin
				seen_q <= seen_q + 1'b1;
			end
		end else if (busy_q && !done) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_q <= elem_ch.data.is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_data_q.prefix_best <= result;
			out_data_q.is_final    <= last_q;
		end
	end

	a_accept_starts_walk: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q && (cnt_q == '0))
		else $error("walk did not start after an accepted element");

	a_commit_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> result_ch.valid && !busy_q)
		else $error("commit did not load the output register");

	a_cnt_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cnt_q <= LW'(KMAX)))
		else $error("walk counter ran past the chain length");

	a_seen_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= LW'(KMAX))
		else $error("seen count ran past KMAX");

	a_final_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && last_q) |=> (seen_q == '0))
		else $error("history not cleared after the last element");

endmodule
`default_nettype wire

[rtl/core/pmsd_cell.sv]
// One cell of the chain: a stored element, a stored prefix total and one candidate step.
`default_nettype none
module pmsd_cell import pmsd_pkg::*; #(
	parameter int KMAX = KMAX_DEF,
	parameter int IDX  = 0
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cell_ctl_t         ctl,
	input  wire logic              active,
	input  wire logic [VAL_W-1:0]  value_in,
	input  wire logic [BEST_W-1:0] best_in,
	input  wire tok_t              tok_in,
	output logic      [VAL_W-1:0]  value_q,
	output logic      [BEST_W-1:0] best_q,
	output tok_t                   tok_s1
);

	localparam int LW   = $clog2(KMAX + 1);
	localparam int PW   = VAL_W + LW;
	localparam int SW   = BEST_W + 1;
	localparam logic [LW-1:0] LEN = LW'(IDX + 1);

	logic [VAL_W-1:0]  peak_n;
	logic [PW-1:0]     prod;
	logic [SW-1:0]     sum;
	logic [BEST_W-1:0] cand;
	tok_t              tok_n;

	always_comb begin
		peak_n = (value_q > tok_in.peak) ? value_q : tok_in.peak;
		prod   = PW'(peak_n) * PW'(LEN);
		sum    = SW'(prod) + SW'(best_q);
		cand   = (sum > SW'(BEST_MAX)) ? BEST_MAX : sum[BEST_W-1:0];
		tok_n.peak = peak_n;
		tok_n.best = (cand > tok_in.best) ? cand : tok_in.best;
	end

	// A cell past the allowed piece length hands the candidate on untouched.
	always_ff @(posedge clk) begin
		tok_s1 <= active ? tok_n : tok_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
			best_q  <= '0;
		end else if (ctl.clear) begin
			value_q <= '0;
			best_q  <= '0;
		end else begin
			if (ctl.shift) begin
				value_q <= value_in;
			end
			if (ctl.commit) begin
				best_q <= best_in;
			end
		end
	end

endmodule
`default_nettype wire
